// ----- rtl/wps_pkg.sv -----
// ----------------------------------------------------------------------------
// wps_pkg
// Shared types and constants of the waypoint sequencer: command and status
// codes, payload structs, configuration record and sizing constants.
// ----------------------------------------------------------------------------
`default_nettype none

package wps_pkg;

  localparam int MAX_WAYPOINTS = 256;
  localparam int IDX_W         = $clog2(MAX_WAYPOINTS);
  localparam int CNT_W         = $clog2(MAX_WAYPOINTS + 1);
  localparam int COORD_W       = 32;
  localparam int STAMP_W       = 40;
  localparam int RADIUS_W      = 31;
  localparam int TIME_CFG_W    = 32;
  localparam int INDEX_OUT_W   = 8;
  localparam int CFG_DATA_W    = 32;
  localparam int CFG_INDEX_W   = 2;
  localparam int QUEUE_DEPTH   = 2;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QFILL_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_WAYPOINTS);

  localparam logic [RADIUS_W-1:0]   RST_REACH_RADIUS    = RADIUS_W'(32768);
  localparam logic [RADIUS_W-1:0]   RST_HEIGHT_BOUND    = RADIUS_W'(327680);
  localparam logic [TIME_CFG_W-1:0] RST_DWELL_MS        = TIME_CFG_W'(0);
  localparam logic [TIME_CFG_W-1:0] RST_FRAME_PERIOD_MS = TIME_CFG_W'(200);

  typedef enum logic [1:0] {
    CMD_APPEND = 2'd0,
    CMD_POSE   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_REACH_RADIUS    = 2'd0,
    CFG_HEIGHT_BOUND    = 2'd1,
    CFG_DWELL_MS        = 2'd2,
    CFG_FRAME_PERIOD_MS = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_EVAL,
    BK_LOAD,
    BK_RESP
  } bk_state_e;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [STAMP_W-1:0]        stamp_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]                status;
    logic [INDEX_OUT_W-1:0]    target_index;
    logic                      dwelling;
    logic                      frame_tick;
    logic                      send_target;
    logic signed [COORD_W-1:0] target_x;
    logic signed [COORD_W-1:0] target_y;
    logic signed [COORD_W-1:0] target_z;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

  typedef struct packed {
    cmd_e               kind;
    point_t             pos;
    logic [STAMP_W-1:0] stamp_ms;
  } wp_item_t;

  typedef struct packed {
    logic [RADIUS_W-1:0]   reach_radius;
    logic [RADIUS_W-1:0]   height_bound;
    logic [TIME_CFG_W-1:0] dwell_ms;
    logic [TIME_CFG_W-1:0] frame_period_ms;
  } cfg_t;

endpackage

`default_nettype wire

// ----- rtl/waypoint_sequencer_unit.sv -----
// ----------------------------------------------------------------------------
// waypoint_sequencer_unit
// Waypoint follower with dwell and rate-limited target publication.
// ----------------------------------------------------------------------------
// Items enter a two-entry queue, so a new item is taken on every cycle in
// which the queue has room, also while a result waits on the output. The back
// end answers an append, a clear, an ignored command or a pose against an
// empty table from its idle state; a pose goes through difference, squaring
// and evaluation steps, and when it advances to the next waypoint, that
// waypoint comes from the registered read port of the table RAM and is
// loaded in a step of its own before the result goes out. Results leave
// through one output register in input order, one per item. A new reach
// radius is registered in the configuration and its square registered from it.
`default_nettype none

module waypoint_sequencer_unit import wps_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  in_item_t               in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output out_item_t              out_data_o
);

  cfg_t     cfg_q, cfg_d;
  logic     q_valid;
  wp_item_t q_item;
  logic     q_pop;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_REACH_RADIUS:    cfg_d.reach_radius    = cfg_data_i[RADIUS_W-1:0];
        CFG_HEIGHT_BOUND:    cfg_d.height_bound    = cfg_data_i[RADIUS_W-1:0];
        CFG_DWELL_MS:        cfg_d.dwell_ms        = cfg_data_i[TIME_CFG_W-1:0];
        CFG_FRAME_PERIOD_MS: cfg_d.frame_period_ms = cfg_data_i[TIME_CFG_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reach_radius    <= RST_REACH_RADIUS;
      cfg_q.height_bound    <= RST_HEIGHT_BOUND;
      cfg_q.dwell_ms        <= RST_DWELL_MS;
      cfg_q.frame_period_ms <= RST_FRAME_PERIOD_MS;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  wps_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_item_o   (q_item),
    .q_pop_i    (q_pop)
  );

  wps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

// ----- rtl/wps_ram.sv -----
// ----------------------------------------------------------------------------
// wps_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module wps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

// ----- rtl/wps_front.sv -----
// ----------------------------------------------------------------------------
// wps_front
// Input side: takes command items, decodes the command and holds them in a
// short queue until the sequencing back end picks them up.
// ----------------------------------------------------------------------------
`default_nettype none

module wps_front import wps_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_item_t in_data_i,
  output logic     q_valid_o,
  output wp_item_t q_item_o,
  input  logic     q_pop_i
);

  wp_item_t            slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QFILL_W-1:0]  fill_q, fill_d;
  logic                push;
  logic                pop;
  wp_item_t            push_item;

  always_comb begin
    push_item.kind     = cmd_e'(in_data_i.cmd);
    push_item.pos.x    = in_data_i.coord_x;
    push_item.pos.y    = in_data_i.coord_y;
    push_item.pos.z    = in_data_i.coord_z;
    push_item.stamp_ms = in_data_i.stamp_ms;
  end

  assign in_stall_o = (fill_q == QFILL_W'(QUEUE_DEPTH));
  assign q_valid_o  = (fill_q != '0);
  assign q_item_o   = slot_q[rd_ptr_q];
  assign push       = in_valid_i && !in_stall_o;
  assign pop        = q_pop_i && q_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_d = rd_ptr_q + QPTR_W'(1);
    end
    unique case ({push, pop})
      2'b10:   fill_d = fill_q + QFILL_W'(1);
      2'b01:   fill_d = fill_q - QFILL_W'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/wps_back.sv -----
// ----------------------------------------------------------------------------
// wps_back
// Sequencing back end: owns the waypoint table, tracks the current waypoint,
// the dwell and the publication timer, and drives the registered result.
// ----------------------------------------------------------------------------
`default_nettype none

module wps_back import wps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_valid_i,
  input  wp_item_t  q_item_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  bk_state_e             state_q, state_d;
  logic [CNT_W-1:0]      count_q, count_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic                  wait_q, wait_d;
  logic [STAMP_W-1:0]    dstart_q, dstart_d;
  logic [STAMP_W-1:0]    lastpub_q, lastpub_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;

  point_t                cur_q, cur_d;
  logic [STAMP_W-1:0]    now_q, now_d;
  logic [COORD_W-1:0]    adx_q, adx_d, ady_q, ady_d, adz_q, adz_d;
  logic                  ltx_q, ltx_d, lty_q, lty_d, ltz_q, ltz_d;
  logic [2*RADIUS_W-1:0] sqx_q, sqx_d, sqy_q, sqy_d;
  logic [2*RADIUS_W-1:0] rsq_q;
  logic                  tick_q, tick_d, dpass_q, dpass_d, more_q, more_d;
  logic                  pend_tick_q, pend_tick_d, pend_send_q, pend_send_d;

  logic                  out_free;
  logic                  emit;
  out_item_t             emit_item;
  logic                  near_xy;
  logic                  reach;
  logic                  advance;
  logic                  new_wait;
  logic                  send;

  logic                  ram_wr_en;
  logic [IDX_W-1:0]      ram_wr_addr;
  logic                  ram_rd_en;
  logic [IDX_W-1:0]      ram_rd_addr;
  logic [$bits(point_t)-1:0] ram_rd_data;

  function automatic logic [COORD_W-1:0] abs_diff(logic [COORD_W-1:0] a,
                                                  logic [COORD_W-1:0] b);
    logic [COORD_W:0] d;
    logic [COORD_W:0] m;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    m = d[COORD_W] ? (~d + (COORD_W+1)'(1)) : d;
    return m[COORD_W-1:0];
  endfunction

  function automatic out_item_t mk_out(status_e st, logic [IDX_W-1:0] idx,
                                       logic dw, logic tk, logic sd,
                                       logic have, point_t p);
    out_item_t o;
    o.status       = st;
    o.target_index = INDEX_OUT_W'(idx);
    o.dwelling     = dw;
    o.frame_tick   = tk;
    o.send_target  = sd;
    o.target_x     = have ? p.x : '0;
    o.target_y     = have ? p.y : '0;
    o.target_z     = have ? p.z : '0;
    return o;
  endfunction

  wps_ram #(
    .WIDTH ($bits(point_t)),
    .DEPTH (MAX_WAYPOINTS)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (q_item_i.pos),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (ram_rd_addr),
    .rd_data_o (ram_rd_data)
  );

  assign out_free    = !out_valid_q || !out_stall_i;
  assign ram_wr_addr = count_q[IDX_W-1:0];
  assign ram_rd_addr = idx_q + IDX_W'(1);

  assign near_xy  = ltx_q && lty_q &&
                    (({1'b0, sqx_q} + {1'b0, sqy_q}) < {1'b0, rsq_q});
  assign reach    = near_xy && ltz_q && !wait_q;
  assign advance  = wait_q && dpass_q && more_q;
  assign new_wait = reach || (wait_q && !advance);
  assign send     = tick_q && !new_wait;

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    wait_d      = wait_q;
    dstart_d    = dstart_q;
    lastpub_d   = lastpub_q;
    cur_d       = cur_q;
    now_d       = now_q;
    adx_d       = adx_q;
    ady_d       = ady_q;
    adz_d       = adz_q;
    ltx_d       = ltx_q;
    lty_d       = lty_q;
    ltz_d       = ltz_q;
    sqx_d       = sqx_q;
    sqy_d       = sqy_q;
    tick_d      = tick_q;
    dpass_d     = dpass_q;
    more_d      = more_q;
    pend_tick_d = pend_tick_q;
    pend_send_d = pend_send_q;
    q_pop_o     = 1'b0;
    emit        = 1'b0;
    emit_item   = out_q;
    ram_wr_en   = 1'b0;
    ram_rd_en   = 1'b0;

    unique case (state_q)
      BK_IDLE: begin
        if (q_valid_i) begin
          unique case (q_item_i.kind)
            CMD_APPEND: begin
              if (out_free) begin
                q_pop_o = 1'b1;
                emit    = 1'b1;
                if (count_q < MAX_CNT) begin
                  ram_wr_en = 1'b1;
                  count_d   = count_q + CNT_W'(1);
                  if (count_q == '0) begin
                    cur_d = q_item_i.pos;
                  end
                  emit_item = mk_out(ST_OK, idx_q, wait_q, 1'b0, 1'b0, 1'b1,
                                     (count_q == '0) ? q_item_i.pos : cur_q);
                end else begin
                  emit_item = mk_out(ST_FULL, idx_q, wait_q, 1'b0, 1'b0, 1'b1,
                                     cur_q);
                end
              end
            end
            CMD_CLEAR: begin
              if (out_free) begin
                q_pop_o   = 1'b1;
                emit      = 1'b1;
                count_d   = '0;
                idx_d     = '0;
                wait_d    = 1'b0;
                dstart_d  = '0;
                lastpub_d = '0;
                emit_item = mk_out(ST_OK, '0, 1'b0, 1'b0, 1'b0, 1'b0, cur_q);
              end
            end
            CMD_NOP: begin
              if (out_free) begin
                q_pop_o   = 1'b1;
                emit      = 1'b1;
                emit_item = mk_out(ST_OK, idx_q, wait_q, 1'b0, 1'b0,
                                   count_q != '0, cur_q);
              end
            end
            CMD_POSE: begin
              if (count_q == '0) begin
                if (out_free) begin
                  q_pop_o   = 1'b1;
                  emit      = 1'b1;
                  emit_item = mk_out(ST_EMPTY, idx_q, wait_q, 1'b0, 1'b0, 1'b0,
                                     cur_q);
                end
              end else begin
                q_pop_o = 1'b1;
                now_d   = q_item_i.stamp_ms;
                adx_d   = abs_diff(q_item_i.pos.x, cur_q.x);
                ady_d   = abs_diff(q_item_i.pos.y, cur_q.y);
                adz_d   = abs_diff(q_item_i.pos.z, cur_q.z);
                state_d = BK_MUL;
              end
            end
          endcase
        end
      end
      BK_MUL: begin
        ltx_d   = adx_q < COORD_W'(cfg_i.reach_radius);
        lty_d   = ady_q < COORD_W'(cfg_i.reach_radius);
        ltz_d   = adz_q < COORD_W'(cfg_i.height_bound);
        sqx_d   = adx_q[RADIUS_W-1:0] * adx_q[RADIUS_W-1:0];
        sqy_d   = ady_q[RADIUS_W-1:0] * ady_q[RADIUS_W-1:0];
        tick_d  = {1'b0, now_q} >
                  ({1'b0, lastpub_q} + (STAMP_W+1)'(cfg_i.frame_period_ms));
        dpass_d = ({1'b0, dstart_q} + (STAMP_W+1)'(cfg_i.dwell_ms)) <
                  {1'b0, now_q};
        more_d  = (CNT_W'(idx_q) + CNT_W'(1)) < count_q;
        state_d = BK_EVAL;
      end
      BK_EVAL: begin
        wait_d      = new_wait;
        pend_tick_d = tick_q;
        pend_send_d = send;
        if (reach) begin
          dstart_d = now_q;
        end
        if (tick_q) begin
          lastpub_d = now_q;
        end
        if (advance) begin
          idx_d     = idx_q + IDX_W'(1);
          ram_rd_en = 1'b1;
          state_d   = BK_LOAD;
        end else if (out_free) begin
          emit      = 1'b1;
          emit_item = mk_out(ST_OK, idx_q, new_wait, tick_q, send, 1'b1, cur_q);
          state_d   = BK_IDLE;
        end else begin
          state_d = BK_RESP;
        end
      end
      BK_LOAD: begin
        cur_d   = point_t'(ram_rd_data);
        state_d = BK_RESP;
      end
      BK_RESP: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_item = mk_out(ST_OK, idx_q, wait_q, pend_tick_q, pend_send_q,
                             1'b1, cur_q);
          state_d   = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
    out_d = emit ? emit_item : out_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      wait_q      <= 1'b0;
      dstart_q    <= '0;
      lastpub_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      wait_q      <= wait_d;
      dstart_q    <= dstart_d;
      lastpub_q   <= lastpub_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q       <= cur_d;
    now_q       <= now_d;
    adx_q       <= adx_d;
    ady_q       <= ady_d;
    adz_q       <= adz_d;
    ltx_q       <= ltx_d;
    lty_q       <= lty_d;
    ltz_q       <= ltz_d;
    sqx_q       <= sqx_d;
    sqy_q       <= sqy_d;
    tick_q      <= tick_d;
    dpass_q     <= dpass_d;
    more_q      <= more_d;
    pend_tick_q <= pend_tick_d;
    pend_send_q <= pend_send_d;
    out_q       <= out_d;
    rsq_q       <= cfg_i.reach_radius * cfg_i.reach_radius;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_idx_below_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != '0 |-> CNT_W'(idx_q) < count_q)
    else $error("Current waypoint index is not below the entry count.");

  a_empty_at_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == '0 |-> idx_q == '0 && !wait_q)
    else $error("Empty table with nonzero index or an active dwell.");

  a_read_then_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_rd_en |=> state_q == BK_LOAD && wait_q == 1'b0)
    else $error("Table read was not followed by the load step.");

  a_empty_zero_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit && emit_item.status == ST_EMPTY |=>
      out_valid_q && out_q.target_x == '0 && out_q.target_y == '0 &&
      out_q.target_z == '0)
    else $error("Result for an empty table carries a nonzero target.");

endmodule

`default_nettype wire
